### hw/rtl/rimz_pkg.sv
// Shared types and constants for the range increment mod 3 zero counter.
// No dependencies; imported by rimz_ctrl, rimz_dp and the top level.
package rimz_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int ADDR_W       = 10;
    localparam int CNT_W        = 11;
    localparam int RES_W        = 2;

    // Item function codes.
    localparam logic FUNC_INC   = 1'b0;
    localparam logic FUNC_COUNT = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic clr_step;
        logic load;
        logic step;
        logic emit;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic clr_last;
        logic in_empty;
        logic run_last;
    } t_status;

endpackage

### hw/rtl/rimz_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rimz_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/rimz_ctrl.sv
// Controller state machine: clearing pass, range sweep and result strobe.
// Depends on rimz_pkg.
module rimz_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_cfg_we,
    input  rimz_pkg::t_status i_status,
    output rimz_pkg::t_cmd    o_cmd,
    output logic              busy,
    output logic              o_valid
);
    import rimz_pkg::*;

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // A size write takes this edge, so no item is taken with it.
                busy = i_cfg_we;
                if (i_cfg_we) begin
                    n_state = S_CLEAR;
                end else if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.in_empty ? S_FINISH : S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_status.run_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        o_valid = o_cmd.emit;
    end
endmodule

### hw/rtl/rimz_dp.sv
// Datapath: size register, range registers, residue memory and zero counter.
// Depends on rimz_pkg and rimz_ram.
module rimz_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rimz_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic                        i_func,
    input  logic [rimz_pkg::ADDR_W-1:0] i_range_low,
    input  logic [rimz_pkg::ADDR_W-1:0] i_range_high,
    input  rimz_pkg::t_cmd              i_cmd,
    output rimz_pkg::t_status           o_status,
    output logic                        o_is_count,
    output logic [rimz_pkg::CNT_W-1:0]  o_zero_count
);
    import rimz_pkg::*;

    logic [CNT_W-1:0]  r_elem_count;
    logic              r_func;
    logic [ADDR_W-1:0] r_hi;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_wr_addr;
    logic              r_rd_vld;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] lim;
    logic [ADDR_W-1:0] hi_clip;
    logic [RES_W-1:0]  rdata;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [RES_W-1:0]  wdata;
    logic [RES_W-1:0]  inc_res;

    // Last usable index from the size register, clamped to 0..MAX_ELEMENTS-1.
    always_comb begin
        if (r_elem_count == '0) begin
            lim = '0;
        end else if (r_elem_count > CNT_W'(MAX_ELEMENTS)) begin
            lim = ADDR_W'(MAX_ELEMENTS - 1);
        end else begin
            lim = ADDR_W'(r_elem_count - CNT_W'(1));
        end
        hi_clip = (i_range_high > lim) ? lim : i_range_high;
    end

    assign o_status.in_empty = i_range_low > hi_clip;
    assign o_status.run_last = r_addr == r_hi;
    assign o_status.clr_last = r_addr == ADDR_W'(MAX_ELEMENTS - 1);

    // Size register; control registers for the sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_count <= CNT_W'(MAX_ELEMENTS);
            r_addr       <= '0;
            r_rd_vld     <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.step;
            if (i_cfg_we) begin
                r_elem_count <= i_cfg_wdata;
                r_addr       <= '0;
            end else if (i_cmd.load) begin
                r_addr <= i_range_low;
            end else if (i_cmd.step || i_cmd.clr_step) begin
                r_addr <= r_addr + ADDR_W'(1);
            end
        end
    end

    // Item payload and the running zero count.
    always_ff @(posedge i_clk) begin
        r_wr_addr <= r_addr;
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_hi    <= hi_clip;
            r_count <= '0;
        end else if (r_rd_vld && r_func == FUNC_COUNT && rdata == '0) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Read-modify-write: residue plus one modulo 3.
    assign inc_res = (rdata == RES_W'(2)) ? '0 : rdata + RES_W'(1);
    assign we      = i_cmd.clr_step || (r_rd_vld && r_func == FUNC_INC);
    assign waddr   = i_cmd.clr_step ? r_addr : r_wr_addr;
    assign wdata   = i_cmd.clr_step ? '0 : inc_res;

    rimz_ram #(
        .WIDTH(RES_W),
        .DEPTH(MAX_ELEMENTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(r_addr),
        .o_rdata(rdata)
    );

    assign o_is_count   = r_func == FUNC_COUNT;
    assign o_zero_count = r_count;
endmodule

### hw/rtl/range_increment_mod3_zero_count.sv
// Top level of the range increment mod 3 zero counter.
// Depends on rimz_pkg, rimz_ctrl and rimz_dp.
//
// An item is taken when start is high and busy is low. The block keeps one
// 2-bit residue per counter in a single-port-write RAM and sweeps the clipped
// range one counter per cycle; the RAM read-modify-write sets that rate. A
// count result appears on o_zero_count with o_valid for one cycle at the end
// of the item and cannot be held off. After reset, and after a write of
// element_count while idle, a clearing pass zeroes all counters with busy
// held high.
module range_increment_mod3_zero_count (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_func,
    input  logic [rimz_pkg::ADDR_W-1:0] i_range_low,
    input  logic [rimz_pkg::ADDR_W-1:0] i_range_high,
    input  logic                        i_cfg_we,
    input  logic [rimz_pkg::CNT_W-1:0]  i_cfg_wdata,
    output logic                        o_valid,
    output logic [rimz_pkg::CNT_W-1:0]  o_zero_count
);
    import rimz_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    fin;
    logic    is_count;

    rimz_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cfg_we(i_cfg_we),
        .i_status(status),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (fin)
    );

    rimz_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_func      (i_func),
        .i_range_low (i_range_low),
        .i_range_high(i_range_high),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_is_count  (is_count),
        .o_zero_count(o_zero_count)
    );

    // Only count items deliver a result.
    assign o_valid = fin && is_count;
endmodule

### hw/rtl/rimz_checker.sv
// Port-level checker for the range increment mod 3 zero counter, bound to the top.
// Depends on range_increment_mod3_zero_count.
module rimz_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [10:0] o_zero_count
);
    // A result only ends an item in progress.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result outside an item");

    // Results are single-cycle strobes.
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    // Reset starts the clearing pass.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> busy) else $error("not busy after reset");

    // An accepted item makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("item accepted but not busy");

    // The count never exceeds the number of counters.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_zero_count <= 11'd1024) else $error("count too large");
endmodule

bind range_increment_mod3_zero_count rimz_checker u_rimz_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_zero_count(o_zero_count)
);
